// File: rtl/agpq_pkg.sv
// Shared types, curve coefficients and gamma threshold builder for the
// tone mapping pixel quantiser. No dependencies.
`timescale 1ns / 1ps

package agpq_pkg;

    localparam int LANES  = 3;
    localparam int PIX_W  = 24;
    localparam int BYTE_W = 8;
    localparam int LEVELS = 2 ** BYTE_W;

    localparam logic [BYTE_W-1:0] ALPHA_BYTE = 8'hFF;

    // Inputs at or above 2^SAT_SHIFT saturate the curve
    localparam int SAT_SHIFT = 3;

    // Filmic curve in hundredths: N = x(251x + 3S), D = x(243x + 59S) + 14S^2
    localparam int C_N_SQ    = 251;
    localparam int C_N_LIN   = 3;
    localparam int C_D_SQ    = 243;
    localparam int C_D_LIN   = 59;
    localparam int C_D_CONST = 14;
    localparam int HEADROOM  = 14;

    // Gamma 1/2.2 = 5/11, byte boundaries at (2k-1)/510
    localparam int GAMMA_NUM   = 5;
    localparam int GAMMA_DEN   = 11;
    localparam int HALF_LEVELS = 510;

    localparam int THR_W = 17;
    localparam int BIG_W = 192;

    typedef logic [THR_W-1:0] thr_t;

    typedef struct packed {
        logic adv;
        logic vld;
    } stage_ctrl_t;

    function automatic logic gamma_reaches(input thr_t idx, input int unsigned k,
                                           input int unsigned g);
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        int               n;
        lhs = BIG_W'(1);
        rhs = BIG_W'(1);
        for (n = 0; n < GAMMA_NUM; n++) begin
            lhs = lhs * BIG_W'(idx);
            rhs = rhs << g;
        end
        for (n = 0; n < GAMMA_DEN; n++) begin
            lhs = lhs * BIG_W'(HALF_LEVELS);
            rhs = rhs * BIG_W'(2 * k - 1);
        end
        return lhs >= rhs;
    endfunction

    // Smallest table index whose gamma value rounds to at least byte k
    function automatic thr_t gamma_threshold(input int unsigned k, input int unsigned g);
        thr_t lo;
        thr_t hi;
        thr_t mid;
        int   step;
        lo = '0;
        hi = THR_W'(1) << g;
        if (k != 0) begin
            for (step = 0; step < THR_W; step++) begin
                if (lo < hi) begin
                    mid = THR_W'(((THR_W + 1)'(lo) + (THR_W + 1)'(hi)) >> 1);
                    if (gamma_reaches(mid, k, g)) begin
                        hi = mid;
                    end else begin
                        lo = mid + THR_W'(1);
                    end
                end
            end
        end
        return lo;
    endfunction

endpackage

// File: rtl/agpq_curve.sv
// Front of the pipeline: input masking, saturation detect and the two
// rational curve products per lane. Depends on agpq_pkg.
`timescale 1ns / 1ps

module agpq_curve #(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 8
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  agpq_pkg::stage_ctrl_t                                 ctrl,
    input  logic [agpq_pkg::LANES-1:0][agpq_pkg::PIX_W-1:0]       x_in,
    output logic [agpq_pkg::LANES-1:0][2*FRAC_BITS+agpq_pkg::HEADROOM-1:0] n_out,
    output logic [agpq_pkg::LANES-1:0][2*FRAC_BITS+agpq_pkg::HEADROOM-1:0] d_out,
    output logic [agpq_pkg::LANES-1:0]                            sat_out,
    output logic                                                  vld_out
);

    localparam int RAW_W = INT_BITS + FRAC_BITS;
    localparam int MW    = (RAW_W < agpq_pkg::PIX_W) ? RAW_W : agpq_pkg::PIX_W;
    localparam int XLIM  = FRAC_BITS + agpq_pkg::SAT_SHIFT;
    localparam int XW    = (XLIM < MW) ? XLIM : MW;
    localparam int AW    = FRAC_BITS + 12;
    localparam int NW    = 2 * FRAC_BITS + agpq_pkg::HEADROOM;

    localparam logic [AW-1:0] N_LIN = AW'(agpq_pkg::C_N_LIN) << FRAC_BITS;
    localparam logic [AW-1:0] D_LIN = AW'(agpq_pkg::C_D_LIN) << FRAC_BITS;
    localparam logic [NW-1:0] D_OFS = NW'(agpq_pkg::C_D_CONST) << (2 * FRAC_BITS);

    logic [XW-1:0]                x_next   [agpq_pkg::LANES];
    logic [AW-1:0]                a_next   [agpq_pkg::LANES];
    logic [AW-1:0]                b_next   [agpq_pkg::LANES];
    logic [agpq_pkg::LANES-1:0]   sat1_next;
    logic [XW-1:0]                x_reg    [agpq_pkg::LANES];
    logic [AW-1:0]                a_reg    [agpq_pkg::LANES];
    logic [AW-1:0]                b_reg    [agpq_pkg::LANES];
    logic [agpq_pkg::LANES-1:0]   sat1_reg;
    logic                         vld1_reg;
    logic [NW-1:0]                n_next   [agpq_pkg::LANES];
    logic [NW-1:0]                d_next   [agpq_pkg::LANES];
    logic [NW-1:0]                n_reg    [agpq_pkg::LANES];
    logic [NW-1:0]                d_reg    [agpq_pkg::LANES];
    logic [agpq_pkg::LANES-1:0]   sat2_reg;
    logic                         vld2_reg;

    for (genvar l = 0; l < agpq_pkg::LANES; l++) begin : g_lane
        if (MW > XW) begin : g_hi
            assign sat1_next[l] = |x_in[l][MW-1:XW];
        end else begin : g_nohi
            assign sat1_next[l] = 1'b0;
        end
        assign x_next[l] = x_in[l][XW-1:0];
        assign a_next[l] = AW'(x_next[l]) * AW'(agpq_pkg::C_N_SQ) + N_LIN;
        assign b_next[l] = AW'(x_next[l]) * AW'(agpq_pkg::C_D_SQ) + D_LIN;
        assign n_next[l] = NW'(x_reg[l]) * NW'(a_reg[l]);
        assign d_next[l] = NW'(x_reg[l]) * NW'(b_reg[l]) + D_OFS;
        assign n_out[l]  = n_reg[l];
        assign d_out[l]  = d_reg[l];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (ctrl.adv) begin
            vld1_reg <= ctrl.vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            sat1_reg <= sat1_next;
            sat2_reg <= sat1_reg;
            for (int l = 0; l < agpq_pkg::LANES; l++) begin
                x_reg[l] <= x_next[l];
                a_reg[l] <= a_next[l];
                b_reg[l] <= b_next[l];
                n_reg[l] <= n_next[l];
                d_reg[l] <= d_next[l];
            end
        end
    end

    assign sat_out = sat2_reg;
    assign vld_out = vld2_reg;

endmodule

// File: rtl/agpq_divide.sv
// Restoring divider, one quotient bit per stage, giving the curve value in
// 0.FRAC_BITS format and a saturation flag per lane. Depends on agpq_pkg.
`timescale 1ns / 1ps

module agpq_divide #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  agpq_pkg::stage_ctrl_t                                 ctrl,
    input  logic [agpq_pkg::LANES-1:0][2*FRAC_BITS+agpq_pkg::HEADROOM-1:0] n_in,
    input  logic [agpq_pkg::LANES-1:0][2*FRAC_BITS+agpq_pkg::HEADROOM-1:0] d_in,
    input  logic [agpq_pkg::LANES-1:0]                            sat_in,
    output logic [agpq_pkg::LANES-1:0][FRAC_BITS-1:0]             q_out,
    output logic [agpq_pkg::LANES-1:0]                            sat_out,
    output logic                                                  vld_out
);

    localparam int NW = 2 * FRAC_BITS + agpq_pkg::HEADROOM;
    localparam int FW = FRAC_BITS;

    logic [NW-1:0]              rem_next [FW][agpq_pkg::LANES];
    logic [NW-1:0]              rem_reg  [FW][agpq_pkg::LANES];
    logic [NW-1:0]              d_next   [FW][agpq_pkg::LANES];
    logic [NW-1:0]              d_reg    [FW][agpq_pkg::LANES];
    logic [FW-1:0]              q_next   [FW+1][agpq_pkg::LANES];
    logic [FW-1:0]              q_reg    [FW+1][agpq_pkg::LANES];
    logic [agpq_pkg::LANES-1:0] sat_next [FW+1];
    logic [agpq_pkg::LANES-1:0] sat_reg  [FW+1];
    logic [FW:0]                vld_reg;

    for (genvar s = 0; s <= FW; s++) begin : g_stage
        for (genvar l = 0; l < agpq_pkg::LANES; l++) begin : g_lane
            if (s == 0) begin : g_load
                assign rem_next[s][l] = n_in[l];
                assign d_next[s][l]   = d_in[l];
                assign q_next[s][l]   = '0;
                assign sat_next[s][l] = sat_in[l] | (n_in[l] >= d_in[l]);
            end else begin : g_step
                logic [NW:0] rem2;
                logic [NW:0] dext;
                logic [NW:0] diff;
                logic        ge;
                assign rem2 = {rem_reg[s-1][l], 1'b0};
                assign dext = {1'b0, d_reg[s-1][l]};
                assign diff = rem2 - dext;
                assign ge   = rem2 >= dext;
                assign q_next[s][l]   = {q_reg[s-1][l][FW-2:0], ge};
                assign sat_next[s][l] = sat_reg[s-1][l];
                if (s < FW) begin : g_carry
                    assign rem_next[s][l] = ge ? diff[NW-1:0] : rem2[NW-1:0];
                    assign d_next[s][l]   = d_reg[s-1][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctrl.adv) begin
            vld_reg <= {vld_reg[FW-1:0], ctrl.vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            for (int s = 0; s <= FW; s++) begin
                sat_reg[s] <= sat_next[s];
                for (int l = 0; l < agpq_pkg::LANES; l++) begin
                    q_reg[s][l] <= q_next[s][l];
                end
            end
            for (int s = 0; s < FW; s++) begin
                for (int l = 0; l < agpq_pkg::LANES; l++) begin
                    rem_reg[s][l] <= rem_next[s][l];
                    d_reg[s][l]   <= d_next[s][l];
                end
            end
        end
    end

    for (genvar l = 0; l < agpq_pkg::LANES; l++) begin : g_out
        assign q_out[l] = q_reg[FW][l];
    end
    assign sat_out = sat_reg[FW];
    assign vld_out = vld_reg[FW];

endmodule

// File: rtl/agpq_gamma.sv
// Gamma 1/2.2 and byte quantisation: binary search of the byte boundary
// table, one result bit per stage. Depends on agpq_pkg.
`timescale 1ns / 1ps

module agpq_gamma #(
    parameter int FRAC_BITS        = 16,
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  agpq_pkg::stage_ctrl_t                                 ctrl,
    input  logic [agpq_pkg::LANES-1:0][FRAC_BITS-1:0]             q_in,
    input  logic [agpq_pkg::LANES-1:0]                            sat_in,
    output logic [agpq_pkg::LANES-1:0][agpq_pkg::BYTE_W-1:0]      byte_out,
    output logic                                                  vld_out
);

    localparam int IW = GAMMA_INDEX_BITS + 1;
    localparam int BW = agpq_pkg::BYTE_W;

    logic [IW-1:0] thr_tab  [agpq_pkg::LEVELS];
    logic [IW-1:0] idx_src  [BW][agpq_pkg::LANES];
    logic [IW-1:0] idx_reg  [BW-1][agpq_pkg::LANES];
    logic [BW-1:0] k_src    [BW][agpq_pkg::LANES];
    logic [BW-1:0] k_next   [BW][agpq_pkg::LANES];
    logic [BW-1:0] k_reg    [BW][agpq_pkg::LANES];
    logic [BW-1:0] vld_reg;

    for (genvar k = 0; k < agpq_pkg::LEVELS; k++) begin : g_thr
        localparam agpq_pkg::thr_t THR_FULL = agpq_pkg::gamma_threshold(k, GAMMA_INDEX_BITS);
        assign thr_tab[k] = THR_FULL[IW-1:0];
    end

    for (genvar j = 0; j < BW; j++) begin : g_stage
        for (genvar l = 0; l < agpq_pkg::LANES; l++) begin : g_lane
            logic [BW-1:0] probe;
            if (j == 0) begin : g_first
                logic [IW-1:0] q_idx;
                if (FRAC_BITS >= GAMMA_INDEX_BITS) begin : g_drop
                    assign q_idx = {1'b0, q_in[l][FRAC_BITS-1 -: GAMMA_INDEX_BITS]};
                end else begin : g_pad
                    assign q_idx = {1'b0, q_in[l], {(GAMMA_INDEX_BITS - FRAC_BITS){1'b0}}};
                end
                assign idx_src[j][l] = sat_in[l] ? (IW'(1) << GAMMA_INDEX_BITS) : q_idx;
                assign k_src[j][l]   = '0;
            end else begin : g_rest
                assign idx_src[j][l] = idx_reg[j-1][l];
                assign k_src[j][l]   = k_reg[j-1][l];
            end
            assign probe        = k_src[j][l] | (BW'(1) << (BW - 1 - j));
            assign k_next[j][l] = (thr_tab[probe] <= idx_src[j][l]) ? probe : k_src[j][l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctrl.adv) begin
            vld_reg <= {vld_reg[BW-2:0], ctrl.vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            for (int l = 0; l < agpq_pkg::LANES; l++) begin
                for (int j = 0; j < BW; j++) begin
                    k_reg[j][l] <= k_next[j][l];
                end
                for (int j = 0; j < BW - 1; j++) begin
                    idx_reg[j][l] <= idx_src[j][l];
                end
            end
        end
    end

    for (genvar l = 0; l < agpq_pkg::LANES; l++) begin : g_out
        assign byte_out[l] = k_reg[BW-1][l];
    end
    assign vld_out = vld_reg[BW-1];

endmodule

// File: rtl/aces_gamma_pixel_quantizer_unit.sv
// Filmic tone map, gamma 1/2.2, to RGBA8: one pixel a clock while not stalled.
// Depends on agpq_pkg, agpq_curve, agpq_divide and agpq_gamma.
//
// Takes one HDR pixel per beat, three unsigned INT_BITS.FRAC_BITS channels,
// and returns one RGBA8 beat with alpha fixed at 255. Each channel runs
// through the filmic curve v(2.51v+0.03)/(v(2.43v+0.59)+0.14), clamped to
// [0,1]; inputs of 8.0 and above give 255 directly. Gamma and rounding come
// from a 256-entry boundary table searched one bit per stage. A new pixel
// is taken every clock while the output buffer is not full. The pipeline
// contains the one-bit-per-stage divider (FRAC_BITS + 1 stages) and the
// eight-stage table search. A two-entry output buffer (output and skid
// registers) takes one more beat when m_ready drops; s_ready falls and the
// whole pipeline holds while the skid register is full.
`timescale 1ns / 1ps

module aces_gamma_pixel_quantizer_unit #(
    parameter int FRAC_BITS        = 16,
    parameter int INT_BITS         = 8,
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [agpq_pkg::PIX_W-1:0]    s_red_in,
    input  logic [agpq_pkg::PIX_W-1:0]    s_green_in,
    input  logic [agpq_pkg::PIX_W-1:0]    s_blue_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [agpq_pkg::BYTE_W-1:0]   m_red_out,
    output logic [agpq_pkg::BYTE_W-1:0]   m_green_out,
    output logic [agpq_pkg::BYTE_W-1:0]   m_blue_out,
    output logic [agpq_pkg::BYTE_W-1:0]   m_alpha_out
);

    localparam int NW = 2 * FRAC_BITS + agpq_pkg::HEADROOM;

    logic                                                 pipe_adv;
    agpq_pkg::stage_ctrl_t                                curve_ctrl;
    agpq_pkg::stage_ctrl_t                                div_ctrl;
    agpq_pkg::stage_ctrl_t                                gam_ctrl;
    logic [agpq_pkg::LANES-1:0][agpq_pkg::PIX_W-1:0]      pix_in;
    logic [agpq_pkg::LANES-1:0][NW-1:0]                   curve_n;
    logic [agpq_pkg::LANES-1:0][NW-1:0]                   curve_d;
    logic [agpq_pkg::LANES-1:0]                           curve_sat;
    logic                                                 curve_vld;
    logic [agpq_pkg::LANES-1:0][FRAC_BITS-1:0]            div_q;
    logic [agpq_pkg::LANES-1:0]                           div_sat;
    logic                                                 div_vld;
    logic [agpq_pkg::LANES-1:0][agpq_pkg::BYTE_W-1:0]     last_rgb;
    logic                                                 last_vld;

    logic [agpq_pkg::LANES-1:0][agpq_pkg::BYTE_W-1:0]     out_rgb_reg;
    logic [agpq_pkg::LANES-1:0][agpq_pkg::BYTE_W-1:0]     out_rgb_next;
    logic                                                 out_vld_reg;
    logic                                                 out_vld_next;
    logic [agpq_pkg::LANES-1:0][agpq_pkg::BYTE_W-1:0]     skid_rgb_reg;
    logic [agpq_pkg::LANES-1:0][agpq_pkg::BYTE_W-1:0]     skid_rgb_next;
    logic                                                 skid_vld_reg;
    logic                                                 skid_vld_next;

    assign pipe_adv = !skid_vld_reg;
    assign s_ready  = pipe_adv;
    assign pix_in   = {s_blue_in, s_green_in, s_red_in};

    assign curve_ctrl = '{adv: pipe_adv, vld: s_valid};
    assign div_ctrl   = '{adv: pipe_adv, vld: curve_vld};
    assign gam_ctrl   = '{adv: pipe_adv, vld: div_vld};

    agpq_curve #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_curve (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (curve_ctrl),
        .x_in    (pix_in),
        .n_out   (curve_n),
        .d_out   (curve_d),
        .sat_out (curve_sat),
        .vld_out (curve_vld)
    );

    agpq_divide #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .n_in    (curve_n),
        .d_in    (curve_d),
        .sat_in  (curve_sat),
        .q_out   (div_q),
        .sat_out (div_sat),
        .vld_out (div_vld)
    );

    agpq_gamma #(
        .FRAC_BITS        (FRAC_BITS),
        .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
    ) u_gamma (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (gam_ctrl),
        .q_in     (div_q),
        .sat_in   (div_sat),
        .byte_out (last_rgb),
        .vld_out  (last_vld)
    );

    always_comb begin
        out_rgb_next  = out_rgb_reg;
        out_vld_next  = out_vld_reg;
        skid_rgb_next = skid_rgb_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_rgb_next  = skid_rgb_reg;
                skid_vld_next = 1'b0;
            end
        end else if (last_vld) begin
            if (!out_vld_reg || m_ready) begin
                out_rgb_next = last_rgb;
                out_vld_next = 1'b1;
            end else begin
                skid_rgb_next = last_rgb;
                skid_vld_next = 1'b1;
            end
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_rgb_reg  <= out_rgb_next;
        skid_rgb_reg <= skid_rgb_next;
    end

    assign m_valid     = out_vld_reg;
    assign m_red_out   = out_rgb_reg[0];
    assign m_green_out = out_rgb_reg[1];
    assign m_blue_out  = out_rgb_reg[2];
    assign m_alpha_out = agpq_pkg::ALPHA_BYTE;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("buffered beat without a beat on the output");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg && m_ready |=> !skid_vld_reg)
        else $error("buffered beat not moved to the output");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_adv && last_vld |=> last_vld && $stable(last_rgb))
        else $error("pipeline tail changed while stalled");
`endif

endmodule
